// ----- hw/rtl/tpc_pkg.sv -----
// ---------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the triangle plane clipper
// Coordinate, vertex, distance and queue item types, the classification
// codes and the configuration register map.
// ---------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

  // Coordinate and shade widths are fixed by the item format.
  localparam int COORD_W = 32;
  localparam int SHADE_W = 16;
  // Exact signed plane distance: three 65-bit products summed.
  localparam int DIST_W = COORD_W + 35;
  // Default number of fraction bits of a coordinate.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register map.
  localparam int REG_COUNT = 6;
  localparam int ADDR_W = 5;
  localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sd65536;

  typedef enum logic [2:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } tpc_reg_t;

  typedef logic signed [COORD_W-1:0] tpc_coord_t;
  typedef logic signed [SHADE_W-1:0] tpc_shade_t;
  typedef logic signed [DIST_W-1:0] tpc_dist_t;
  // Index 0 is x, 1 is y, 2 is z.
  typedef tpc_coord_t [2:0] tpc_vtx_t;
  typedef tpc_vtx_t [2:0] tpc_tri_t;

  // How many vertices lie inside the plane.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_ONE,
    KIND_TWO
  } tpc_kind_t;

  typedef struct packed {
    tpc_vtx_t point;
    tpc_vtx_t normal;
  } tpc_plane_t;

  // Classified triangle. Vertices are reordered as p, q, r:
  // all inside keeps a, b, c; one inside gives i0, o0, o1;
  // two inside gives i0, i1, o0. Distances follow the same order.
  typedef struct packed {
    tpc_kind_t        kind;
    tpc_shade_t       shade;
    tpc_tri_t         v;
    tpc_dist_t [2:0]  d;
  } tpc_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tpc_if.sv -----
// ---------------------------------------------------------------------------
// tpc_if: channel interfaces of the triangle plane clipper
// One interface for input triangles and one for result triangles.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpc_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_ax;
  logic signed [31:0] in_ay;
  logic signed [31:0] in_az;
  logic signed [31:0] in_bx;
  logic signed [31:0] in_by;
  logic signed [31:0] in_bz;
  logic signed [31:0] in_cx;
  logic signed [31:0] in_cy;
  logic signed [31:0] in_cz;
  logic signed [15:0] in_shade;

  modport source(output valid, in_ax, in_ay, in_az, in_bx, in_by, in_bz,
                 in_cx, in_cy, in_cz, in_shade, input ready);
  modport sink(input valid, in_ax, in_ay, in_az, in_bx, in_by, in_bz,
               in_cx, in_cy, in_cz, in_shade, output ready);
endinterface

interface tpc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_ax;
  logic signed [31:0] out_ay;
  logic signed [31:0] out_az;
  logic signed [31:0] out_bx;
  logic signed [31:0] out_by;
  logic signed [31:0] out_bz;
  logic signed [31:0] out_cx;
  logic signed [31:0] out_cy;
  logic signed [31:0] out_cz;
  logic signed [15:0] out_shade;
  logic               last_piece;

  modport source(output valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                 out_cx, out_cy, out_cz, out_shade, last_piece, input ready);
  modport sink(input valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
               out_cx, out_cy, out_cz, out_shade, last_piece, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/triangle_plane_clipper_top.sv -----
// ---------------------------------------------------------------------------
// triangle_plane_clipper_top: clips triangles against one configured plane
// APB register file, classifier front, queue and clipping back end.
// ---------------------------------------------------------------------------
// The block takes a triangle on every cycle unless a full queue to the
// back end holds it up, and returns zero, one or two clipped triangles
// for it, in input order. A triangle wholly inside, or with one vertex
// inside, gives one piece; one with two vertices inside yields two pieces
// on the single result port, and the back end takes no new item until the
// second has left. The pipeline is 3 classifier stages, the queue, a setup
// stage, (FRAC_BITS+1)/2 divider stages of two quotient bits each, a
// multiply stage and the result register. The plane registers may only be
// written while no triangle is in flight.
`default_nettype none

module triangle_plane_clipper_top import tpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  tpc_tri_if.sink           tri_in,
  tpc_res_if.source         res_out
);

  tpc_plane_t plane;
  tpc_reg_t   reg_idx;
  logic       cfg_write;
  tpc_item_t  push_item, pop_item;
  logic       push_valid, push_ready, pop_valid, pop_ready;

  assign pready    = 1'b1;
  assign reg_idx   = tpc_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Plane registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane.point     <= '0;
      plane.normal[0] <= '0;
      plane.normal[1] <= '0;
      plane.normal[2] <= NORMAL_Z_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_POINT_X:  plane.point[0]  <= pwdata;
        REG_POINT_Y:  plane.point[1]  <= pwdata;
        REG_POINT_Z:  plane.point[2]  <= pwdata;
        REG_NORMAL_X: plane.normal[0] <= pwdata;
        REG_NORMAL_Y: plane.normal[1] <= pwdata;
        REG_NORMAL_Z: plane.normal[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_POINT_X:  prdata = plane.point[0];
      REG_POINT_Y:  prdata = plane.point[1];
      REG_POINT_Z:  prdata = plane.point[2];
      REG_NORMAL_X: prdata = plane.normal[0];
      REG_NORMAL_Y: prdata = plane.normal[1];
      REG_NORMAL_Z: prdata = plane.normal[2];
      default:      prdata = '0;
    endcase
  end

  tpc_front u_front (
    .clk, .rst, .tri_in, .plane,
    .push_item, .push_valid, .push_ready
  );

  tpc_queue u_queue (
    .clk, .rst, .push_item, .push_valid, .push_ready,
    .pop_item, .pop_valid, .pop_ready
  );

  tpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .pop_item, .pop_valid, .pop_ready, .res_out
  );

  // The second piece of a split triangle follows the first at once.
  a_second_piece: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.ready && !res_out.last_piece |=> res_out.valid)
    else $error("second piece of a split triangle missing");

  // Both pieces of a split triangle carry the same shade.
  a_piece_shade: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.ready && !res_out.last_piece
    |=> res_out.out_shade == $past(res_out.out_shade))
    else $error("shade changed between pieces");

  // A write beyond the register list leaves the plane unchanged.
  a_bad_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (paddr[ADDR_W-1:2] >= 3'(REG_COUNT)) |=> $stable(plane))
    else $error("write beyond the register list changed the plane");

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_front.sv -----
// ---------------------------------------------------------------------------
// tpc_front: distance pipeline and classifier
// Three stages compute the exact signed distance of each vertex from the
// plane, then the triangle is classified and its vertices reordered.
// ---------------------------------------------------------------------------
`default_nettype none

module tpc_front import tpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tpc_tri_if.sink    tri_in,
  input  tpc_plane_t plane,
  output tpc_item_t  push_item,
  output logic       push_valid,
  input  logic       push_ready
);

  tpc_tri_t           in_tri;
  logic               en;
  logic               v1, v2, v3;
  tpc_tri_t           vt1, vt2, vt3;
  tpc_shade_t         sh1, sh2, sh3;
  logic signed [32:0] diff1 [3][3];
  logic signed [64:0] prod2 [3][3];
  tpc_dist_t          dist3 [3];
  logic [2:0]         in_mask;
  tpc_kind_t          kind;
  logic [1:0]         sel_p, sel_q, sel_r;

  // Gather the input vertices into an array.
  assign in_tri[0] = {tri_in.in_az, tri_in.in_ay, tri_in.in_ax};
  assign in_tri[1] = {tri_in.in_bz, tri_in.in_by, tri_in.in_bx};
  assign in_tri[2] = {tri_in.in_cz, tri_in.in_cy, tri_in.in_cx};

  // The pipeline moves whenever its last stage is empty or leaves.
  assign en = !v3 || (kind == KIND_NONE) || push_ready;
  assign tri_in.ready = en;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage one: vertex minus plane point; stage two: products with the
  // normal; stage three: sum of the products.
  always_ff @(posedge clk) begin
    if (en) begin
      vt1 <= in_tri;
      sh1 <= tri_in.in_shade;
      vt2 <= vt1;
      sh2 <= sh1;
      vt3 <= vt2;
      sh3 <= sh2;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          diff1[j][k] <= 33'(in_tri[j][k]) - 33'(plane.point[k]);
          prod2[j][k] <= diff1[j][k] * plane.normal[k];
        end
        dist3[j] <= DIST_W'(prod2[j][0]) + DIST_W'(prod2[j][1])
                    + DIST_W'(prod2[j][2]);
      end
    end
  end

  // Classify by the sign of each distance; zero counts as inside.
  assign in_mask = {~dist3[2][DIST_W-1], ~dist3[1][DIST_W-1], ~dist3[0][DIST_W-1]};

  always_comb begin
    unique case (in_mask)
      3'b111: begin kind = KIND_ALL;  sel_p = 2'd0; sel_q = 2'd1; sel_r = 2'd2; end
      3'b001: begin kind = KIND_ONE;  sel_p = 2'd0; sel_q = 2'd1; sel_r = 2'd2; end
      3'b010: begin kind = KIND_ONE;  sel_p = 2'd1; sel_q = 2'd0; sel_r = 2'd2; end
      3'b100: begin kind = KIND_ONE;  sel_p = 2'd2; sel_q = 2'd0; sel_r = 2'd1; end
      3'b011: begin kind = KIND_TWO;  sel_p = 2'd0; sel_q = 2'd1; sel_r = 2'd2; end
      3'b101: begin kind = KIND_TWO;  sel_p = 2'd0; sel_q = 2'd2; sel_r = 2'd1; end
      3'b110: begin kind = KIND_TWO;  sel_p = 2'd1; sel_q = 2'd2; sel_r = 2'd0; end
      default: begin kind = KIND_NONE; sel_p = 2'd0; sel_q = 2'd1; sel_r = 2'd2; end
    endcase
  end

  // Reordered item toward the queue; triangles fully outside are dropped.
  always_comb begin
    push_item.kind  = kind;
    push_item.shade = sh3;
    push_item.v[0]  = vt3[sel_p];
    push_item.v[1]  = vt3[sel_q];
    push_item.v[2]  = vt3[sel_r];
    push_item.d[0]  = dist3[sel_p];
    push_item.d[1]  = dist3[sel_q];
    push_item.d[2]  = dist3[sel_r];
  end

  assign push_valid = v3 && (kind != KIND_NONE);

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_queue.sv -----
// ---------------------------------------------------------------------------
// tpc_queue: two-entry queue between classifier and clipper
// Lets the front keep accepting triangles while the back is stalled, until both entries are full.
// ---------------------------------------------------------------------------
`default_nettype none

module tpc_queue import tpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tpc_item_t push_item,
  input  logic      push_valid,
  output logic      push_ready,
  output tpc_item_t pop_item,
  output logic      pop_valid,
  input  logic      pop_ready
);

  tpc_item_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_back.sv -----
// ---------------------------------------------------------------------------
// tpc_back: edge cut pipeline and result sequencer
// Two restoring dividers, two quotient bits per stage, find the cut
// fractions; a multiply stage and the holding stage, which rounds, place
// the cut points, and the holding stage sends one or two result triangles.
// ---------------------------------------------------------------------------
`default_nettype none

module tpc_back import tpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  tpc_item_t pop_item,
  input  logic      pop_valid,
  output logic      pop_ready,
  tpc_res_if.source res_out
);

  localparam int ND = (FRAC_BITS + 1) / 2;
  localparam int NS = ND + 1;
  localparam int RW = DIST_W + 1;
  localparam int PW = FRAC_BITS + 34;
  localparam int AW = PW + 1;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic en, done;

  // Setup and divider stages.
  logic                 sv   [NS];
  tpc_kind_t            sk   [NS];
  tpc_shade_t           ssh  [NS];
  tpc_tri_t             svt  [NS];
  logic [RW-1:0]        sden [NS][2];
  logic [RW-1:0]        srem [NS][2];
  logic [FRAC_BITS-1:0] squo [NS][2];

  // Multiply stage.
  logic               mv;
  tpc_kind_t          mk;
  tpc_shade_t         msh;
  tpc_tri_t           mvt;
  logic signed [PW-1:0] mprod [2][3];

  // Result holding stage.
  logic       hv, hph;
  tpc_kind_t  hk;
  tpc_shade_t hsh;
  tpc_tri_t   hvt;
  tpc_vtx_t   hx [2];
  tpc_tri_t   o_tri;

  // Start vertex of cut c.
  function automatic tpc_vtx_t cut_start(tpc_kind_t kind, tpc_tri_t vt, logic c);
    return (kind == KIND_TWO && c) ? vt[1] : vt[0];
  endfunction

  // End vertex of cut c.
  function automatic tpc_vtx_t cut_end(tpc_kind_t kind, tpc_tri_t vt, logic c);
    tpc_vtx_t e;
    unique case (kind)
      KIND_ONE: e = c ? vt[2] : vt[1];
      KIND_TWO: e = vt[2];
      default:  e = vt[0];
    endcase
    return e;
  endfunction

  // An item leaves the holding stage with its last piece.
  assign done = hv && res_out.ready && (hk != KIND_TWO || hph);
  assign en = !hv || done;
  assign pop_ready = en;

  // Setup: pick the two cuts and form the divisors.
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= pop_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk[0]  <= pop_item.kind;
      ssh[0] <= pop_item.shade;
      svt[0] <= pop_item.v;
      for (int c = 0; c < 2; c++) begin
        logic signed [DIST_W-1:0] ds, de;
        ds = (pop_item.kind == KIND_TWO && c == 1) ? pop_item.d[1] : pop_item.d[0];
        de = (pop_item.kind == KIND_ONE && c == 0) ? pop_item.d[1] : pop_item.d[2];
        sden[0][c] <= RW'(ds) - RW'(de);
        srem[0][c] <= {1'b0, ds};
        squo[0][c] <= '0;
      end
    end
  end

  // Divider stages, two quotient bits each.
  for (genvar s = 1; s < NS; s++) begin : g_div
    logic [RW-1:0]        drem [2];
    logic [FRAC_BITS-1:0] dquo [2];

    always_comb begin
      logic [RW-1:0]        r;
      logic [FRAC_BITS-1:0] q;
      for (int c = 0; c < 2; c++) begin
        r = srem[s-1][c];
        q = squo[s-1][c];
        for (int t = 0; t < 2; t++) begin
          if (2 * (s - 1) + t < FRAC_BITS) begin
            r = {r[RW-2:0], 1'b0};
            if (r >= sden[s-1][c]) begin
              r = r - sden[s-1][c];
              q = {q[FRAC_BITS-2:0], 1'b1};
            end else begin
              q = {q[FRAC_BITS-2:0], 1'b0};
            end
          end
        end
        drem[c] = r;
        dquo[c] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[s] <= 1'b0;
      else if (en) sv[s] <= sv[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sk[s]  <= sk[s-1];
        ssh[s] <= ssh[s-1];
        svt[s] <= svt[s-1];
        for (int c = 0; c < 2; c++) begin
          sden[s][c] <= sden[s-1][c];
          srem[s][c] <= drem[c];
          squo[s][c] <= dquo[c];
        end
      end
    end
  end

  // Multiply stage: edge vector times cut fraction.
  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else if (en) mv <= sv[NS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk  <= sk[NS-1];
      msh <= ssh[NS-1];
      mvt <= svt[NS-1];
      for (int c = 0; c < 2; c++) begin
        tpc_vtx_t sv0, ev0;
        logic signed [32:0] delta;
        sv0 = cut_start(sk[NS-1], svt[NS-1], 1'(c));
        ev0 = cut_end(sk[NS-1], svt[NS-1], 1'(c));
        for (int k = 0; k < 3; k++) begin
          delta = 33'(ev0[k]) - 33'(sv0[k]);
          mprod[c][k] <= delta * $signed({1'b0, squo[NS-1][c]});
        end
      end
    end
  end

  // Holding stage: round, add the start vertex, and sequence the pieces.
  always_ff @(posedge clk) begin
    if (rst) begin
      hv  <= 1'b0;
      hph <= 1'b0;
    end else if (en) begin
      hv  <= mv;
      hph <= 1'b0;
    end else if (hv && res_out.ready) begin
      hph <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hk  <= mk;
      hsh <= msh;
      hvt <= mvt;
      for (int c = 0; c < 2; c++) begin
        tpc_vtx_t sv0;
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] sh;
        sv0 = cut_start(mk, mvt, 1'(c));
        for (int k = 0; k < 3; k++) begin
          acc = AW'(mprod[c][k]) + HALF;
          sh  = acc >>> FRAC_BITS;
          hx[c][k] <= sv0[k] + tpc_coord_t'(sh[COORD_W-1:0]);
        end
      end
    end
  end

  // Pick the triangle of the current piece.
  always_comb begin
    unique case (hk)
      KIND_ONE: o_tri = {hx[1], hx[0], hvt[0]};
      KIND_TWO: o_tri = hph ? {hx[1], hx[0], hvt[1]} : {hx[0], hvt[1], hvt[0]};
      default:  o_tri = hvt;
    endcase
  end

  assign res_out.valid      = hv;
  assign res_out.out_ax     = o_tri[0][0];
  assign res_out.out_ay     = o_tri[0][1];
  assign res_out.out_az     = o_tri[0][2];
  assign res_out.out_bx     = o_tri[1][0];
  assign res_out.out_by     = o_tri[1][1];
  assign res_out.out_bz     = o_tri[1][2];
  assign res_out.out_cx     = o_tri[2][0];
  assign res_out.out_cy     = o_tri[2][1];
  assign res_out.out_cz     = o_tri[2][2];
  assign res_out.out_shade  = hsh;
  assign res_out.last_piece = (hk != KIND_TWO) || hph;

endmodule

`default_nettype wire

// ----- bench/tpc_clip_scoreboard.sv -----
// ---------------------------------------------------------------------------
// tpc_clip_scoreboard: expected clip pieces of the triangle plane clipper
// Holds a copy of the plane registers, works out the pieces each accepted
// triangle should give, and checks the result items against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import tpc_pkg::*;

class tpc_clip_scoreboard;

  typedef struct {
    tpc_tri_t   v;
    tpc_shade_t shade;
    logic       last;
  } piece_t;

  tpc_coord_t   plane_reg [REG_COUNT];
  piece_t       pending_pieces [$];
  int unsigned  mismatches;
  int           frac_bits;

  function new(int fb);
    frac_bits = fb;
    mismatches = 0;
    foreach (plane_reg[i]) plane_reg[i] = '0;
    plane_reg[REG_NORMAL_Z] = NORMAL_Z_RESET;
  endfunction

  function void set_reg(int idx, tpc_coord_t val);
    if (idx < REG_COUNT) plane_reg[idx] = val;
  endfunction

  // Exact signed distance N.(V - P).
  function logic signed [127:0] plane_dist(tpc_vtx_t vtx);
    logic signed [127:0] acc;
    logic signed [127:0] diff;
    logic signed [127:0] nrm;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      diff = 128'(signed'(vtx[k])) - 128'(signed'(plane_reg[REG_POINT_X + k]));
      nrm = 128'(signed'(plane_reg[REG_NORMAL_X + k]));
      acc = acc + diff * nrm;
    end
    return acc;
  endfunction

  // Cut point between inside vertex s and outside vertex e.
  function tpc_vtx_t cut_point(tpc_vtx_t s, logic signed [127:0] ds,
                               tpc_vtx_t e, logic signed [127:0] de);
    logic [127:0] den;
    logic [127:0] rem;
    logic [63:0] q;
    logic signed [127:0] acc;
    tpc_vtx_t res;
    den = ds - de;
    rem = ds;
    q = 0;
    for (int i = 0; i < frac_bits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      acc = (128'(signed'(e[k])) - 128'(signed'(s[k]))) * signed'({1'b0, q});
      acc = acc + (128'sd1 <<< (frac_bits - 1));
      acc = acc >>> frac_bits;
      res[k] = tpc_coord_t'(128'(signed'(s[k])) + acc);
    end
    return res;
  endfunction

  function void add_piece(tpc_vtx_t a, tpc_vtx_t b, tpc_vtx_t c,
                          tpc_shade_t shade, logic last);
    piece_t p;
    p.v[0] = a;
    p.v[1] = b;
    p.v[2] = c;
    p.shade = shade;
    p.last = last;
    pending_pieces = {pending_pieces, p};
  endfunction

  // Notes an accepted triangle and queues the pieces it should give.
  function void note_triangle(tpc_tri_t t, tpc_shade_t shade);
    logic signed [127:0] d [3];
    int ins [3];
    int outs [3];
    int n_in;
    int n_out;
    tpc_vtx_t x0, x1;
    n_in = 0;
    n_out = 0;
    for (int j = 0; j < 3; j++) begin
      d[j] = plane_dist(t[j]);
      if (d[j] < 0) begin
        outs[n_out] = j;
        n_out++;
      end else begin
        ins[n_in] = j;
        n_in++;
      end
    end
    case (n_in)
      3: begin
        add_piece(t[0], t[1], t[2], shade, 1'b1);
      end
      1: begin
        x0 = cut_point(t[ins[0]], d[ins[0]], t[outs[0]], d[outs[0]]);
        x1 = cut_point(t[ins[0]], d[ins[0]], t[outs[1]], d[outs[1]]);
        add_piece(t[ins[0]], x0, x1, shade, 1'b1);
      end
      2: begin
        x0 = cut_point(t[ins[0]], d[ins[0]], t[outs[0]], d[outs[0]]);
        x1 = cut_point(t[ins[1]], d[ins[1]], t[outs[0]], d[outs[0]]);
        add_piece(t[ins[0]], t[ins[1]], x0, shade, 1'b0);
        add_piece(t[ins[1]], x0, x1, shade, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  // Checks one result item against the oldest expected piece.
  function void check_piece(tpc_tri_t v, tpc_shade_t shade, logic last);
    piece_t p;
    string nm;
    if (pending_pieces.size() == 0) begin
      mismatches++;
      $error("result item with no piece expected");
      return;
    end
    p = pending_pieces[0];
    pending_pieces.delete(0);
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        nm = $sformatf("out_%s%s", j == 0 ? "a" : j == 1 ? "b" : "c",
                       k == 0 ? "x" : k == 1 ? "y" : "z");
        cmp(nm, p.v[j][k], v[j][k]);
      end
    end
    cmp("out_shade", 32'(p.shade), 32'(shade));
    cmp("last_piece", 32'(p.last), 32'(last));
  endfunction
endclass

// ----- bench/triangle_plane_clipper_top_tb.sv -----
// ---------------------------------------------------------------------------
// triangle_plane_clipper_top_tb: testbench of the triangle plane clipper
// Writes several planes over APB, sends directed and random triangles in
// bursts, stalls the result side, and checks every piece in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_plane_clipper_top_tb;
  import tpc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 64;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  tpc_tri_if tri_ch ();
  tpc_res_if res_ch ();

  tpc_clip_scoreboard clip_sb;
  bit hold_results;
  bit stall_pattern_on;

  triangle_plane_clipper_top #(.FRAC_BITS(FB)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tri_in  (tri_ch.sink),
    .res_out (res_ch.source)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety limit on run time.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stall pattern, long hold-off when asked.
  initial begin
    int stall_left;
    res_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
      end else if (!stall_pattern_on) begin
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    tpc_tri_t v;
    if (!rst && res_ch.valid && res_ch.ready) begin
      v[0] = {res_ch.out_az, res_ch.out_ay, res_ch.out_ax};
      v[1] = {res_ch.out_bz, res_ch.out_by, res_ch.out_bx};
      v[2] = {res_ch.out_cz, res_ch.out_cy, res_ch.out_cx};
      clip_sb.check_piece(v, res_ch.out_shade, res_ch.last_piece);
    end
  end

  // One APB register write, mirrored into the scoreboard.
  task automatic write_plane_reg(tpc_reg_t idx, tpc_coord_t val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clip_sb.set_reg(int'(idx), val);
  endtask

  task automatic write_plane(tpc_vtx_t pt, tpc_vtx_t nrm);
    write_plane_reg(REG_POINT_X, pt[0]);
    write_plane_reg(REG_POINT_Y, pt[1]);
    write_plane_reg(REG_POINT_Z, pt[2]);
    write_plane_reg(REG_NORMAL_X, nrm[0]);
    write_plane_reg(REG_NORMAL_Y, nrm[1]);
    write_plane_reg(REG_NORMAL_Z, nrm[2]);
  endtask

  // Offers one triangle until it is accepted. Valid stays high for the next
  // item when another follows at once.
  task automatic send_triangle(tpc_tri_t t, tpc_shade_t shade, bit keep_valid);
    tri_ch.valid <= 1'b1;
    {tri_ch.in_az, tri_ch.in_ay, tri_ch.in_ax} <= t[0];
    {tri_ch.in_bz, tri_ch.in_by, tri_ch.in_bx} <= t[1];
    {tri_ch.in_cz, tri_ch.in_cy, tri_ch.in_cx} <= t[2];
    tri_ch.in_shade <= shade;
    do @(posedge clk); while (!tri_ch.ready);
    clip_sb.note_triangle(t, shade);
    @(negedge clk);
    if (!keep_valid) tri_ch.valid <= 1'b0;
  endtask

  // Waits until every expected piece has come, then lets the pipe settle.
  task automatic drain_pieces();
    while (clip_sb.pending_pieces.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Builds a vertex from its x, y and z coordinates.
  function automatic tpc_vtx_t make_vtx(tpc_coord_t x, tpc_coord_t y, tpc_coord_t z);
    tpc_vtx_t vtx;
    vtx[0] = x;
    vtx[1] = y;
    vtx[2] = z;
    return vtx;
  endfunction

  function automatic tpc_coord_t rand_coord(int mode);
    case (mode)
      0: return tpc_coord_t'($urandom);
      1: return tpc_coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return tpc_coord_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endcase
  endfunction

  function automatic tpc_tri_t rand_triangle(int mode);
    tpc_tri_t t;
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < 3; k++) t[j][k] = rand_coord(mode);
    return t;
  endfunction

  // Random triangles in bursts with random gaps. Valid stays high across
  // a burst boundary that has no gap.
  task automatic send_random_burst(int count, int mode);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 8)) : 0;
      for (int b = 0; b < burst && sent < count; b++) begin
        sent++;
        send_triangle(rand_triangle($urandom_range(0, 5) == 0 ? 0 : mode),
                      tpc_shade_t'($urandom),
                      (b != burst - 1 || gap == 0) && sent < count);
      end
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    tpc_vtx_t pt, nrm;
    tpc_tri_t t;
    int hold_cycles;
    clip_sb = new(FB);
    hold_results = 1'b0;
    stall_pattern_on = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tri_ch.valid = 1'b0;
    {tri_ch.in_ax, tri_ch.in_ay, tri_ch.in_az} = '0;
    {tri_ch.in_bx, tri_ch.in_by, tri_ch.in_bz} = '0;
    {tri_ch.in_cx, tri_ch.in_cy, tri_ch.in_cz} = '0;
    tri_ch.in_shade = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // Directed: reset plane z >= 0, all four outcomes and a vertex on it.
    t[0] = make_vtx(32'sd0, 32'sd0, 32'sd65536);
    t[1] = make_vtx(32'sd0, 32'sd65536, 32'sd65536);
    t[2] = make_vtx(32'sd65536, 32'sd0, 32'sd65536);
    send_triangle(t, 16'sh7fff, 1'b1);
    t[0] = make_vtx(32'sd0, 32'sd0, -32'sd65536);
    t[1] = make_vtx(32'sd0, 32'sd0, -32'sd1);
    t[2] = make_vtx(32'sd0, 32'sd0, 32'sh8000_0000);
    send_triangle(t, 16'sh8000, 1'b1);
    t[0] = make_vtx(32'sd5, 32'sd0, 32'sd131072);
    t[1] = make_vtx(32'sd0, -32'sd7, -32'sd65536);
    t[2] = make_vtx(32'sh7fff_ffff, 32'sh8000_0000, -32'sd3);
    send_triangle(t, 16'sd1, 1'b1);
    t[0] = make_vtx(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    t[1] = make_vtx(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
    t[2] = make_vtx(32'sd0, 32'sd0, 32'sd0);
    send_triangle(t, -16'sd1, 1'b1);
    t[0] = make_vtx(32'sd0, 32'sd0, 32'sd0);
    t[1] = make_vtx(32'sd0, 32'sd0, 32'sd0);
    t[2] = make_vtx(32'sd0, 32'sd0, 32'sd0);
    send_triangle(t, 16'sd0, 1'b0);
    drain_pieces();

    // Zero normal: everything passes.
    write_plane('{32'sd12345, -32'sd777, 32'sh7fff_ffff}, '{32'sd0, 32'sd0, 32'sd0});
    send_triangle('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                    '{32'sd1, 32'sd2, 32'sd3}, '{-32'sd4, 32'sd5, -32'sd6}}, 16'sd9, 1'b0);
    drain_pieces();

    // Extreme plane values.
    write_plane('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000},
                '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
    for (int i = 0; i < 8; i++) send_triangle(rand_triangle(0), tpc_shade_t'($urandom), i < 7);
    drain_pieces();

    // Random phases over several planes.
    stall_pattern_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 3; k++) begin
        pt[k] = rand_coord(ph == 5 ? 0 : 1);
        nrm[k] = ph == 5 ? tpc_coord_t'($urandom) : rand_coord(1);
      end
      write_plane(pt, nrm);
      if (ph == 2) begin
        // Long hold-off on the result side while triangles keep coming.
        fork
          begin
            hold_results = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 300) begin
              @(negedge clk);
              hold_cycles++;
            end
            hold_results = 1'b0;
          end
          send_random_burst(130, 1);
        join
      end else begin
        send_random_burst(130, ph == 5 ? 0 : 1 + ph % 2);
      end
      if (ph == 3) stall_pattern_on = 1'b0;
      if (ph == 4) stall_pattern_on = 1'b1;
      drain_pieces();
    end

    if (clip_sb.mismatches == 0 && clip_sb.pending_pieces.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_if.sv
hw/rtl/tpc_front.sv
hw/rtl/tpc_queue.sv
hw/rtl/tpc_back.sv
hw/rtl/triangle_plane_clipper_top.sv
bench/tpc_clip_scoreboard.sv
bench/triangle_plane_clipper_top_tb.sv
